FILE: rtl/core/sit_pkg.sv
// shared types and codes for the scoped init tracker
// used by sit_cell and scoped_init_tracker; no dependencies
package sit_pkg;

   typedef enum logic [2:0] {
      ACT_USE          = 3'd0,
      ACT_INIT         = 3'd1,
      ACT_START_BRANCH = 3'd2,
      ACT_SWITCH       = 3'd3,
      ACT_END_BRANCH   = 3'd4,
      ACT_START_LOOP   = 3'd5,
      ACT_END_LOOP     = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      KIND_SCOPE     = 2'd0,
      KIND_BRANCHING = 2'd1,
      KIND_LOOP      = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_MISMATCH = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   localparam int OUT_WIDTH = 32;

   // per-cell update command
   typedef struct packed {
      logic load;
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

FILE: rtl/core/sit_cell.sv
// one frame of the shift stack: kind, masks and first-branch flag
// depends on sit_pkg; takes a local load or shifts by two frames
module sit_cell import sit_pkg::*; #(
   parameter int TAPE_COUNT = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  kind_type              load_kind,
   input  logic                  load_flag,
   input  logic [TAPE_COUNT-1:0] load_init,
   input  logic [TAPE_COUNT-1:0] load_uninit,
   input  kind_type              up_kind,
   input  logic                  up_flag,
   input  logic [TAPE_COUNT-1:0] up_init,
   input  logic [TAPE_COUNT-1:0] up_uninit,
   input  kind_type              down_kind,
   input  logic                  down_flag,
   input  logic [TAPE_COUNT-1:0] down_init,
   input  logic [TAPE_COUNT-1:0] down_uninit,
   output kind_type              q_kind,
   output logic                  q_flag,
   output logic [TAPE_COUNT-1:0] q_init,
   output logic [TAPE_COUNT-1:0] q_uninit
);

   kind_type              kind_ff, kind_in;
   logic                  flag_ff, flag_in;
   logic [TAPE_COUNT-1:0] init_ff, init_in;
   logic [TAPE_COUNT-1:0] uninit_ff, uninit_in;

   always_comb begin
      kind_in   = kind_ff;
      flag_in   = flag_ff;
      init_in   = init_ff;
      uninit_in = uninit_ff;
      if (ctl.load) begin
         kind_in   = load_kind;
         flag_in   = load_flag;
         init_in   = load_init;
         uninit_in = load_uninit;
      end else if (ctl.push) begin
         kind_in   = up_kind;
         flag_in   = up_flag;
         init_in   = up_init;
         uninit_in = up_uninit;
      end else if (ctl.pop) begin
         kind_in   = down_kind;
         flag_in   = down_flag;
         init_in   = down_init;
         uninit_in = down_uninit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_SCOPE;
         flag_ff   <= 1'b0;
         init_ff   <= '0;
         uninit_ff <= '0;
      end else begin
         kind_ff   <= kind_in;
         flag_ff   <= flag_in;
         init_ff   <= init_in;
         uninit_ff <= uninit_in;
      end
   end

   assign q_kind   = kind_ff;
   assign q_flag   = flag_ff;
   assign q_init   = init_ff;
   assign q_uninit = uninit_ff;

endmodule

FILE: rtl/core/scoped_init_tracker.sv
// Scoped tape-initialization tracker, top level.
// The result strobe rises in the cycle after the request is taken.
// Throughput: one request per cycle while busy is low; the stack is a row of
// frame cells, top frame in cell 0; a push or pop is one shift by two cells.
// Reset leaves one empty scope; busy is high during reset and the cycle after.
// The receiver cannot stall: each result is shown for exactly one cycle.
module scoped_init_tracker import sit_pkg::*; #(
   parameter int TAPE_COUNT  = 32,
   parameter int STACK_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_action,
   input  logic [4:0]           req_tape,
   output logic                 rsp_valid,
   output logic [OUT_WIDTH-1:0] rsp_uninit_mask,
   output logic [OUT_WIDTH-1:0] rsp_init_mask,
   output logic [1:0]           rsp_status
);

   localparam int TW = TAPE_COUNT;
   localparam int SW = $clog2(STACK_DEPTH);

   kind_type        kind_q   [STACK_DEPTH];
   logic            flag_q   [STACK_DEPTH];
   logic [TW-1:0]   init_q   [STACK_DEPTH];
   logic [TW-1:0]   uninit_q [STACK_DEPTH];

   logic            busy_ff;
   logic [SW-1:0]   top_ff, top_in;
   logic            rsp_valid_ff;
   logic [TW-1:0]   rsp_init_ff, rsp_init_in;
   logic [TW-1:0]   rsp_uninit_ff, rsp_uninit_in;
   status_type      rsp_status_ff, rsp_status_in;

   logic            accept;
   action_type      act;
   logic [TW-1:0]   bit_v;
   logic            overflow;
   logic            close_branch_ok, close_loop_ok, switch_ok;

   logic [TW-1:0]   fold_init, fold_uninit;
   logic [TW-1:0]   mrg_uninit_b, mrg_init_b, mrg_uninit_l;

   cell_ctl_type    ctl0, ctl1, ctl_rest;
   kind_type        c0_kind;
   logic            c0_flag;
   logic [TW-1:0]   c0_init, c0_uninit;
   kind_type        push_kind;

   assign accept = start & ~busy_ff;
   assign act    = action_type'(req_action);

   always_comb begin
      for (int i = 0; i < TW; i++) begin
         bit_v[i] = (32'(req_tape) == i);
      end
   end

   assign overflow = ({1'b0, top_ff} + (SW+1)'(2)) >= (SW+1)'(STACK_DEPTH);

   assign switch_ok = (top_ff >= SW'(1)) && (kind_q[0] == KIND_SCOPE)
                      && (kind_q[1] == KIND_BRANCHING);
   assign close_branch_ok = (top_ff >= SW'(2)) && (kind_q[0] == KIND_SCOPE)
                            && (kind_q[1] == KIND_BRANCHING) && (kind_q[2] == KIND_SCOPE);
   assign close_loop_ok = (top_ff >= SW'(2)) && (kind_q[0] == KIND_SCOPE)
                          && (kind_q[1] == KIND_LOOP) && (kind_q[2] == KIND_SCOPE);

   // finished branch folded into its branching marker
   assign fold_init   = flag_q[1] ? init_q[0]   : (init_q[1] & init_q[0]);
   assign fold_uninit = flag_q[1] ? uninit_q[0] : (uninit_q[1] | uninit_q[0]);

   // init merge sees the parent's already updated uninit mask
   assign mrg_uninit_b = uninit_q[2] | (fold_uninit & ~init_q[2]);
   assign mrg_init_b   = init_q[2] | (fold_init & ~mrg_uninit_b);
   assign mrg_uninit_l = uninit_q[2] | (uninit_q[0] & ~init_q[2]);

   always_comb begin
      c0_kind       = kind_q[0];
      c0_flag       = flag_q[0];
      c0_init       = init_q[0];
      c0_uninit     = uninit_q[0];
      ctl0          = '{load: accept, push: 1'b0, pop: 1'b0};
      ctl1          = '0;
      ctl_rest      = '0;
      push_kind     = KIND_BRANCHING;
      top_in        = top_ff;
      rsp_status_in = STAT_OK;
      if (accept) begin
         case (act)
            ACT_USE: begin
               c0_uninit = uninit_q[0] | (bit_v & ~init_q[0]);
            end
            ACT_INIT: begin
               c0_init = init_q[0] | (bit_v & ~uninit_q[0]);
            end
            ACT_START_BRANCH, ACT_START_LOOP: begin
               if (overflow) begin
                  rsp_status_in = STAT_OVERFLOW;
               end else begin
                  push_kind = (act == ACT_START_LOOP) ? KIND_LOOP : KIND_BRANCHING;
                  c0_kind   = KIND_SCOPE;
                  c0_flag   = 1'b0;
                  c0_init   = '0;
                  c0_uninit = '0;
                  ctl1      = '{load: 1'b0, push: 1'b1, pop: 1'b0};
                  ctl_rest  = '{load: 1'b0, push: 1'b1, pop: 1'b0};
                  top_in    = top_ff + SW'(2);
               end
            end
            ACT_SWITCH: begin
               if (!switch_ok) begin
                  rsp_status_in = STAT_MISMATCH;
               end else begin
                  c0_init   = '0;
                  c0_uninit = '0;
                  ctl1      = '{load: 1'b1, push: 1'b0, pop: 1'b0};
               end
            end
            ACT_END_BRANCH: begin
               if (!close_branch_ok) begin
                  rsp_status_in = STAT_MISMATCH;
               end else begin
                  c0_kind   = kind_q[2];
                  c0_flag   = flag_q[2];
                  c0_init   = mrg_init_b;
                  c0_uninit = mrg_uninit_b;
                  ctl1      = '{load: 1'b0, push: 1'b0, pop: 1'b1};
                  ctl_rest  = '{load: 1'b0, push: 1'b0, pop: 1'b1};
                  top_in    = top_ff - SW'(2);
               end
            end
            ACT_END_LOOP: begin
               if (!close_loop_ok) begin
                  rsp_status_in = STAT_MISMATCH;
               end else begin
                  c0_kind   = kind_q[2];
                  c0_flag   = flag_q[2];
                  c0_init   = init_q[2];
                  c0_uninit = mrg_uninit_l;
                  ctl1      = '{load: 1'b0, push: 1'b0, pop: 1'b1};
                  ctl_rest  = '{load: 1'b0, push: 1'b0, pop: 1'b1};
                  top_in    = top_ff - SW'(2);
               end
            end
            default: begin
            end
         endcase
      end
      rsp_init_in   = c0_init;
      rsp_uninit_in = c0_uninit;
   end

   genvar g;
   generate
      for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
         cell_ctl_type   ctl_g;
         kind_type       lk, uk, dk;
         logic           lf, uf, df;
         logic [TW-1:0]  li, lu, ui, uu, di, du;

         if (g == 0) begin : g_top
            assign ctl_g = ctl0;
            assign lk = c0_kind;
            assign lf = c0_flag;
            assign li = c0_init;
            assign lu = c0_uninit;
            assign uk = KIND_SCOPE;
            assign uf = 1'b0;
            assign ui = '0;
            assign uu = '0;
         end else if (g == 1) begin : g_marker
            assign ctl_g = ctl1;
            assign lk = kind_q[1];
            assign lf = 1'b0;
            assign li = fold_init;
            assign lu = fold_uninit;
            assign uk = push_kind;
            assign uf = 1'b1;
            assign ui = '0;
            assign uu = '0;
         end else begin : g_body
            assign ctl_g = ctl_rest;
            assign lk = kind_q[g];
            assign lf = flag_q[g];
            assign li = init_q[g];
            assign lu = uninit_q[g];
            assign uk = kind_q[g-2];
            assign uf = flag_q[g-2];
            assign ui = init_q[g-2];
            assign uu = uninit_q[g-2];
         end

         if (g + 2 < STACK_DEPTH) begin : g_down
            assign dk = kind_q[g+2];
            assign df = flag_q[g+2];
            assign di = init_q[g+2];
            assign du = uninit_q[g+2];
         end else begin : g_end
            assign dk = KIND_SCOPE;
            assign df = 1'b0;
            assign di = '0;
            assign du = '0;
         end

         sit_cell #(
            .TAPE_COUNT(TAPE_COUNT)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl_g),
            .load_kind   (lk),
            .load_flag   (lf),
            .load_init   (li),
            .load_uninit (lu),
            .up_kind     (uk),
            .up_flag     (uf),
            .up_init     (ui),
            .up_uninit   (uu),
            .down_kind   (dk),
            .down_flag   (df),
            .down_init   (di),
            .down_uninit (du),
            .q_kind      (kind_q[g]),
            .q_flag      (flag_q[g]),
            .q_init      (init_q[g]),
            .q_uninit    (uninit_q[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         top_ff       <= top_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_init_ff   <= rsp_init_in;
         rsp_uninit_ff <= rsp_uninit_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   generate
      if (TW >= OUT_WIDTH) begin : g_out_trunc
         assign rsp_init_mask   = rsp_init_ff[OUT_WIDTH-1:0];
         assign rsp_uninit_mask = rsp_uninit_ff[OUT_WIDTH-1:0];
      end else begin : g_out_ext
         assign rsp_init_mask   = {{(OUT_WIDTH-TW){1'b0}}, rsp_init_ff};
         assign rsp_uninit_mask = {{(OUT_WIDTH-TW){1'b0}}, rsp_uninit_ff};
      end
   endgenerate

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
